### src/nat_mapping_table_unit_defines.svh
// assertion macros used by the nat mapping table engine
`ifndef NAT_MAPPING_TABLE_UNIT_DEFINES_SVH
`define NAT_MAPPING_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define NMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/nmt_pkg.sv
`default_nettype none
package nmt_pkg;

  localparam int TABLE_SLOTS_DEFAULT = 64;

  // commands
  localparam logic [1:0] CMD_LOOKUP_EXT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP_INT = 2'd1;
  localparam logic [1:0] CMD_INSERT     = 2'd2;
  localparam logic [1:0] CMD_TICK       = 2'd3;

  // result status codes
  localparam logic [2:0] ST_HIT  = 3'd0;
  localparam logic [2:0] ST_MISS = 3'd1;
  localparam logic [2:0] ST_NEW  = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_TICK = 3'd4;

  // mapping kinds
  localparam logic TYPE_ICMP = 1'b0;
  localparam logic TYPE_TCP  = 1'b1;

  // configuration register indexes
  localparam logic CFG_IDLE_LIMIT    = 1'b0;
  localparam logic CFG_ICMP_ID_START = 1'b1;

  localparam logic [15:0] IDLE_LIMIT_RESET    = 16'd60;
  localparam logic [15:0] ICMP_ID_START_RESET = 16'd0;
  localparam logic [15:0] TCP_ID_FLOOR        = 16'd1024;
  localparam logic [6:0]  REMOVED_MAX         = 7'd127;

  // one queued request
  typedef struct packed {
    logic [1:0]  command;
    logic        map_type;
    logic [31:0] internal_ip;
    logic [15:0] internal_port;
    logic [15:0] external_port;
  } req_t;

  // one table slot
  typedef struct packed {
    logic        valid;
    logic        map_type;
    logic [31:0] internal_ip;
    logic [15:0] internal_port;
    logic [15:0] external_port;
    logic [31:0] last_used;
  } slot_t;

  // one result
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_internal_ip;
    logic [15:0] found_internal_port;
    logic [15:0] found_external_port;
    logic        found_type;
    logic [6:0]  removed_count;
  } resp_t;

  // handshake between request queue and engine
  typedef struct packed {
    logic valid;
    req_t req;
  } queue_out_t;

endpackage
`default_nettype wire

### src/nat_mapping_table_unit.sv
`default_nettype none
// NAT mapping table with TABLE_SLOTS slots held in one memory. Requests enter a two-entry
// queue; an engine then scans the slots one per cycle through the memory's single read port.
// A lookup or insert that hits a slot ends its scan early at that slot; all other requests
// scan every slot. The engine starts the next request only once the previous result has
// been transferred, and after reset the table is cleared by a pass over all slots before
// the first request is served. Configuration is to be written only while no request is
// queued or in progress. The result sits in an output register until transferred, and the
// queue keeps taking requests meanwhile until both of its entries are filled.
module nat_mapping_table_unit #(
  parameter int TABLE_SLOTS = nmt_pkg::TABLE_SLOTS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // internal_ip, internal_port, external_port
  input  wire logic [63:0] s_tdata,
  // command, map_type
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // found_internal_ip, found_internal_port, found_external_port, removed_count, zero pad
  output logic [71:0]      m_tdata,
  // status, found_type
  output logic [3:0]       m_tuser,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);
  import nmt_pkg::*;

  queue_out_t q_out;
  logic       q_pop;
  resp_t      resp;

  nmt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_out    (q_out),
    .q_pop    (q_pop)
  );

  nmt_engine #(.TABLE_SLOTS(TABLE_SLOTS)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_out     (q_out),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .resp      (resp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // pack the result transfer
  assign m_tdata = {1'b0, resp.removed_count, resp.found_external_port,
                    resp.found_internal_port, resp.found_internal_ip};
  assign m_tuser = {resp.found_type, resp.status};
endmodule
`default_nettype wire

### src/nmt_front.sv
`default_nettype none
module nmt_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [63:0]        s_tdata,
  input  wire logic [2:0]         s_tuser,
  output nmt_pkg::queue_out_t     q_out,
  input  wire logic               q_pop
);
  import nmt_pkg::*;

  req_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  req_t       in_req;

  // unpack the incoming transfer
  always_comb begin
    in_req.command       = s_tuser[1:0];
    in_req.map_type      = s_tuser[2];
    in_req.internal_ip   = s_tdata[31:0];
    in_req.internal_port = s_tdata[47:32];
    in_req.external_port = s_tdata[63:48];
  end

  assign s_tready    = (count != 2'd2);
  assign push        = s_tvalid && s_tready;
  assign q_out.valid = (count != 2'd0);
  assign q_out.req   = entries[rd_ptr];

  // two-entry request queue
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_req;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

### src/nmt_engine.sv
`default_nettype none
`include "nat_mapping_table_unit_defines.svh"
module nmt_engine #(
  parameter int TABLE_SLOTS = nmt_pkg::TABLE_SLOTS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire nmt_pkg::queue_out_t q_out,
  output logic                    q_pop,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output nmt_pkg::resp_t          resp,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import nmt_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;

  slot_t mem [TABLE_SLOTS];
  slot_t rd_data;

  logic [1:0]        state;
  logic [SLOT_W-1:0] cnt;
  logic              issuing;
  logic              iss;
  logic [SLOT_W-1:0] iss_idx;
  req_t              cur;
  logic              have_free;
  logic [SLOT_W-1:0] free_idx;
  logic [6:0]        removed;
  logic [31:0]       seconds_now;
  logic [15:0]       next_icmp_id;
  logic [15:0]       next_tcp_id;
  logic [15:0]       idle_limit;

  logic              rd_en;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  slot_t             wr_data;
  logic              evaluate;
  logic              hit;
  logic              expire;
  logic              at_last;
  logic              finish;
  logic              free_any;
  logic [SLOT_W-1:0] free_sel;
  logic              do_insert;
  logic [6:0]        removed_next;
  logic [15:0]       tcp_inc;
  logic [15:0]       tcp_next;
  logic [31:0]       idle_time;
  resp_t             res;

  assign q_pop = (state == S_IDLE) && q_out.valid && (!m_tvalid || m_tready);
  assign rd_en = (state == S_SCAN) && issuing;

  // slot memory, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[cnt];
  end

  // per-slot match and expiry checks
  always_comb begin
    evaluate  = (state == S_SCAN) && iss;
    idle_time = seconds_now - rd_data.last_used;
    hit = 1'b0;
    unique case (cur.command)
      CMD_LOOKUP_EXT: hit = rd_data.valid && rd_data.external_port == cur.external_port
                            && rd_data.map_type == cur.map_type;
      CMD_LOOKUP_INT,
      CMD_INSERT:     hit = rd_data.valid && rd_data.internal_ip == cur.internal_ip
                            && rd_data.internal_port == cur.internal_port
                            && rd_data.map_type == cur.map_type;
      default:        hit = 1'b0;
    endcase
    hit     = hit && evaluate;
    expire  = evaluate && (cur.command == CMD_TICK) && rd_data.valid
              && (rd_data.map_type == TYPE_ICMP) && (idle_time > {16'd0, idle_limit});
    at_last = (iss_idx == LAST_SLOT);
    finish  = evaluate && (hit || at_last);
    free_any = have_free || !rd_data.valid;
    free_sel = have_free ? free_idx : iss_idx;
    do_insert = evaluate && at_last && !hit && (cur.command == CMD_INSERT) && free_any;
    removed_next = removed;
    if (expire && removed != REMOVED_MAX) removed_next = removed + 7'd1;
    tcp_inc  = next_tcp_id + 16'd1;
    tcp_next = (tcp_inc == 16'd0) ? TCP_ID_FLOOR : tcp_inc;
  end

  // write port: clear sweep, refresh, expiry or new slot
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = iss_idx;
    wr_data = rd_data;
    priority if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = cnt;
      wr_data = '0;
    end else if (hit) begin
      wr_en             = 1'b1;
      wr_data.last_used = seconds_now;
    end else if (expire) begin
      wr_en         = 1'b1;
      wr_data.valid = 1'b0;
    end else if (do_insert) begin
      wr_en                 = 1'b1;
      wr_addr               = free_sel;
      wr_data.valid         = 1'b1;
      wr_data.map_type      = cur.map_type;
      wr_data.internal_ip   = cur.internal_ip;
      wr_data.internal_port = cur.internal_port;
      wr_data.external_port = (cur.map_type == TYPE_ICMP) ? next_icmp_id : next_tcp_id;
      wr_data.last_used     = seconds_now;
    end else begin
      wr_en = 1'b0;
    end
  end

  // result formed on the final slot of a scan
  always_comb begin
    res = '0;
    priority if (hit) begin
      res.status              = ST_HIT;
      res.found_internal_ip   = rd_data.internal_ip;
      res.found_internal_port = rd_data.internal_port;
      res.found_external_port = rd_data.external_port;
      res.found_type          = rd_data.map_type;
    end else if (cur.command == CMD_TICK) begin
      res.status        = ST_TICK;
      res.removed_count = removed_next;
    end else if (do_insert) begin
      res.status              = ST_NEW;
      res.found_internal_ip   = wr_data.internal_ip;
      res.found_internal_port = wr_data.internal_port;
      res.found_external_port = wr_data.external_port;
      res.found_type          = wr_data.map_type;
    end else if (cur.command == CMD_INSERT) begin
      res.status = ST_FULL;
    end else begin
      res.status = ST_MISS;
    end
  end

  // sequencer, identifiers and configuration
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_out.req;
    if (finish) resp <= res;
    if (rst) begin
      state        <= S_CLEAR;
      cnt          <= '0;
      issuing      <= 1'b0;
      iss          <= 1'b0;
      iss_idx      <= '0;
      have_free    <= 1'b0;
      free_idx     <= '0;
      removed      <= '0;
      seconds_now  <= '0;
      next_icmp_id <= ICMP_ID_START_RESET;
      next_tcp_id  <= TCP_ID_FLOOR;
      idle_limit   <= IDLE_LIMIT_RESET;
      m_tvalid     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + SLOT_W'(1);
          if (cnt == LAST_SLOT) begin
            state <= S_IDLE;
            cnt   <= '0;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            state     <= S_SCAN;
            cnt       <= '0;
            issuing   <= 1'b1;
            iss       <= 1'b0;
            have_free <= 1'b0;
            removed   <= '0;
            if (q_out.req.command == CMD_TICK) seconds_now <= seconds_now + 32'd1;
          end
        end
        S_SCAN: begin
          iss     <= issuing;
          iss_idx <= cnt;
          if (issuing) begin
            cnt <= cnt + SLOT_W'(1);
            if (cnt == LAST_SLOT) issuing <= 1'b0;
          end
          if (evaluate && !rd_data.valid && !have_free) begin
            have_free <= 1'b1;
            free_idx  <= iss_idx;
          end
          removed <= removed_next;
          if (do_insert) begin
            if (cur.map_type == TYPE_ICMP) next_icmp_id <= next_icmp_id + 16'd1;
            else next_tcp_id <= tcp_next;
          end
          if (finish) begin
            state    <= S_IDLE;
            issuing  <= 1'b0;
            iss      <= 1'b0;
            cnt      <= '0;
            m_tvalid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IDLE_LIMIT:    idle_limit   <= cfg_data;
          CFG_ICMP_ID_START: next_icmp_id <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  `NMT_ASSERT_NOW(a_idle_no_write, state == S_IDLE, !wr_en, "table written while idle")
  `NMT_ASSERT_NOW(a_pop_when_free, q_pop, !m_tvalid || m_tready, "pop with result pending")
  `NMT_ASSERT_NOW(a_removed_tick_only, m_tvalid && resp.status != ST_TICK,
                  resp.removed_count == 7'd0, "removed count outside a tick")
  `NMT_ASSERT_NEXT(a_scan_after_pop, q_pop, state == S_SCAN, "no scan after pop")
endmodule
`default_nettype wire

### tb/sv/nat_mapping_table_unit_tb.sv
`default_nettype none
module nat_mapping_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nmt_pkg::*;

  localparam int SLOTS = 64;
  localparam int DRAIN_CYCLES = SLOTS + 40;

  // expected-result store with its own copy of the mapping table
  class nat_table_scoreboard;
    logic        valid_q[SLOTS];
    logic        kind_q[SLOTS];
    logic [31:0] ip_q[SLOTS];
    logic [15:0] iport_q[SLOTS];
    logic [15:0] eport_q[SLOTS];
    logic [31:0] used_q[SLOTS];
    logic [31:0] now_sec;
    logic [15:0] timeout_sec;
    logic [15:0] icmp_next;
    logic [15:0] tcp_next;
    resp_t       expected_q[$];
    int          errors;

    function new();
      for (int i = 0; i < SLOTS; i++) valid_q[i] = 1'b0;
      now_sec = '0;
      timeout_sec = IDLE_LIMIT_RESET;
      icmp_next = ICMP_ID_START_RESET;
      tcp_next = TCP_ID_FLOOR;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] val);
      if (idx == CFG_IDLE_LIMIT) timeout_sec = val;
      else icmp_next = val;
    endfunction

    function int match_int(req_t r);
      for (int i = 0; i < SLOTS; i++)
        if (valid_q[i] && ip_q[i] == r.internal_ip && iport_q[i] == r.internal_port &&
            kind_q[i] == r.map_type) return i;
      return -1;
    endfunction

    function resp_t slot_resp(logic [2:0] st, int i);
      resp_t e;
      e = '0;
      e.status = st;
      e.found_internal_ip = ip_q[i];
      e.found_internal_port = iport_q[i];
      e.found_external_port = eport_q[i];
      e.found_type = kind_q[i];
      return e;
    endfunction

    // note an accepted request and queue its predicted result
    function void note(req_t r);
      resp_t e;
      int hit;
      int freed;
      e = '0;
      hit = -1;
      freed = 0;
      case (r.command)
        CMD_LOOKUP_EXT, CMD_LOOKUP_INT: begin
          if (r.command == CMD_LOOKUP_EXT) begin
            for (int i = 0; i < SLOTS; i++)
              if (hit < 0 && valid_q[i] && eport_q[i] == r.external_port &&
                  kind_q[i] == r.map_type) hit = i;
          end else begin
            hit = match_int(r);
          end
          if (hit < 0) e.status = ST_MISS;
          else begin
            used_q[hit] = now_sec;
            e = slot_resp(ST_HIT, hit);
          end
        end
        CMD_INSERT: begin
          hit = match_int(r);
          if (hit >= 0) begin
            used_q[hit] = now_sec;
            e = slot_resp(ST_HIT, hit);
          end else begin
            for (int i = 0; i < SLOTS; i++) if (hit < 0 && !valid_q[i]) hit = i;
            if (hit < 0) e.status = ST_FULL;
            else begin
              valid_q[hit] = 1'b1;
              kind_q[hit] = r.map_type;
              ip_q[hit] = r.internal_ip;
              iport_q[hit] = r.internal_port;
              used_q[hit] = now_sec;
              if (r.map_type == TYPE_ICMP) begin
                eport_q[hit] = icmp_next;
                icmp_next = icmp_next + 16'd1;
              end else begin
                eport_q[hit] = tcp_next;
                tcp_next = tcp_next + 16'd1;
                if (tcp_next == 16'd0) tcp_next = TCP_ID_FLOOR;
              end
              e = slot_resp(ST_NEW, hit);
            end
          end
        end
        default: begin
          now_sec = now_sec + 32'd1;
          for (int i = 0; i < SLOTS; i++)
            if (valid_q[i] && kind_q[i] == TYPE_ICMP &&
                (now_sec - used_q[i]) > {16'd0, timeout_sec}) begin
              valid_q[i] = 1'b0;
              freed++;
            end
          e.status = ST_TICK;
          e.removed_count = (freed > 127) ? REMOVED_MAX : 7'(freed);
        end
      endcase
      expected_q.push_back(e);
    endfunction

    function void field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    // compare one transferred result with the oldest prediction
    function void check(resp_t a);
      resp_t e;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result expected none actual %h", $time, a);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      field("status", e.status, a.status);
      field("found_internal_ip", e.found_internal_ip, a.found_internal_ip);
      field("found_internal_port", e.found_internal_port, a.found_internal_port);
      field("found_external_port", e.found_external_port, a.found_external_port);
      field("found_type", e.found_type, a.found_type);
      field("removed_count", e.removed_count, a.removed_count);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  nat_table_scoreboard sb;
  logic        no_idle;
  int          stall_left = 0;
  logic [31:0] tcp_ips[8];

  nat_mapping_table_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function int gap_len();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // receiver stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (no_idle) begin
      m_tready <= 1'b1;
    end else if ($urandom_range(99) < 3) begin
      stall_left <= $urandom_range(50, 10);
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) < 70);
    end
  end

  // result side transfers
  always @(posedge clk) begin
    resp_t a;
    if (!rst && m_tvalid && m_tready) begin
      a.status = m_tuser[2:0];
      a.found_type = m_tuser[3];
      a.found_internal_ip = m_tdata[31:0];
      a.found_internal_port = m_tdata[47:32];
      a.found_external_port = m_tdata[63:48];
      a.removed_count = m_tdata[70:64];
      sb.check(a);
    end
  end

  task automatic send(req_t r);
    int n;
    n = gap_len();
    if (n > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= {r.map_type, r.command};
    s_tdata <= {r.external_port, r.internal_port, r.internal_ip};
    do @(posedge clk); while (!s_tready);
    sb.note(r);
  endtask

  task automatic send_fields(logic [1:0] c, logic t, logic [31:0] ip, logic [15:0] ip_port,
                             logic [15:0] ep);
    req_t r;
    r.command = c;
    r.map_type = t;
    r.internal_ip = ip;
    r.internal_port = ip_port;
    r.external_port = ep;
    send(r);
  endtask

  // pause until every predicted result has been transferred
  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // random request, biased toward keys that are in the table
  task automatic send_random();
    req_t r;
    int k;
    int p;
    k = $urandom_range(SLOTS - 1);
    p = $urandom_range(99);
    r.internal_ip = $urandom();
    r.internal_port = $urandom_range(65535);
    r.external_port = $urandom_range(65535);
    r.map_type = $urandom_range(1);
    if (p < 38) r.command = CMD_INSERT;
    else if (p < 58) r.command = CMD_LOOKUP_INT;
    else if (p < 78) r.command = CMD_LOOKUP_EXT;
    else r.command = CMD_TICK;
    if ($urandom_range(99) < 60 && sb.valid_q[k]) begin
      r.internal_ip = sb.ip_q[k];
      r.internal_port = sb.iport_q[k];
      r.external_port = sb.eport_q[k];
      if ($urandom_range(9) != 0) r.map_type = sb.kind_q[k];
    end else if (r.command == CMD_INSERT) begin
      // new tcp keys come from a small pool, as ticks never free them
      if ($urandom_range(9) < 8) r.map_type = TYPE_ICMP;
      if (r.map_type == TYPE_TCP) begin
        r.internal_ip = tcp_ips[$urandom_range(7)];
        r.internal_port = $urandom_range(4);
      end
    end
    send(r);
  endtask

  initial begin
    logic [15:0] tmo_set[4];
    logic [15:0] id_set[4];
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_IDLE_LIMIT;
    cfg_data = '0;
    no_idle = 1'b0;
    for (int i = 0; i < 8; i++) tcp_ips[i] = $urandom();
    tmo_set = '{16'hFFFF, 16'd0, 16'd3, 16'd1};
    id_set = '{16'hFFFE, 16'd100, 16'hFFFF, 16'd0};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, every command, existing match, misses and ticks
    send_fields(CMD_INSERT, TYPE_ICMP, 32'h0, 16'h0, 16'h0);
    send_fields(CMD_INSERT, TYPE_TCP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_fields(CMD_INSERT, TYPE_TCP, 32'hFFFF_FFFF, 16'hFFFF, 16'h0);
    send_fields(CMD_INSERT, TYPE_ICMP, 32'hFFFF_FFFF, 16'hFFFF, 16'h0);
    send_fields(CMD_LOOKUP_EXT, TYPE_ICMP, 32'h0, 16'h0, 16'h0);
    send_fields(CMD_LOOKUP_EXT, TYPE_TCP, 32'h0, 16'h0, TCP_ID_FLOOR);
    send_fields(CMD_LOOKUP_EXT, TYPE_ICMP, 32'h0, 16'h0, TCP_ID_FLOOR);
    send_fields(CMD_LOOKUP_EXT, TYPE_TCP, 32'h0, 16'h0, 16'hFFFF);
    send_fields(CMD_LOOKUP_INT, TYPE_TCP, 32'hFFFF_FFFF, 16'hFFFF, 16'h0);
    send_fields(CMD_LOOKUP_INT, TYPE_ICMP, 32'h0, 16'h0, 16'hFFFF);
    send_fields(CMD_LOOKUP_INT, TYPE_TCP, 32'h0, 16'h0, 16'h0);
    send_fields(CMD_TICK, TYPE_ICMP, 32'h0, 16'h0, 16'h0);
    send_fields(CMD_TICK, TYPE_TCP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    repeat (300) send_random();
    drain();

    // several settings; id wrap makes duplicate external ids, max timeout fills the table
    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(CFG_IDLE_LIMIT, tmo_set[ph]);
      write_cfg(CFG_ICMP_ID_START, id_set[ph]);
      no_idle = (ph == 2);
      if (ph == 0) begin
        send_fields(CMD_INSERT, TYPE_ICMP, 32'h1234_5678, 16'h1, 16'h0);
        send_fields(CMD_INSERT, TYPE_ICMP, 32'h1234_5678, 16'h2, 16'h0);
        send_fields(CMD_INSERT, TYPE_ICMP, 32'h1234_5678, 16'h3, 16'h0);
        send_fields(CMD_LOOKUP_EXT, TYPE_ICMP, 32'h0, 16'h0, 16'h0);
        repeat (SLOTS + 4) send_fields(CMD_INSERT, TYPE_ICMP, $urandom(), $urandom_range(65535),
                                       16'h0);
      end
      repeat (300) send_random();
      drain();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("nat_mapping_table_unit regression: pass");
    end else begin
      $display("nat_mapping_table_unit regression: fail");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #10ms;
    $display("nat_mapping_table_unit regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
